@@ design/ffna_pkg.sv @@
// Shared widths, codes and controller states for the named first-fit allocator.
`timescale 1ns / 1ps

package ffna_pkg;

    // Field widths of the stream payloads
    localparam int ADDR_W = 17;
    localparam int KEY_W  = 32;
    localparam int SIZE_W = 17;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;

    // Byte-padded tdata widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 24;

    // Highest usable address; the top gap ends one above it
    localparam int ADDR_LIMIT = 65536;

    // Default table depths
    localparam int MAX_BLOCKS_DEF = 256;
    localparam int MAX_NAMES_DEF  = 256;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_PRINT = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_UNKNOWN = 2'd1,
        STAT_NOFIT   = 2'd2,
        STAT_FULL    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NSCAN,
        ST_DISPATCH,
        ST_BLOCK,
        ST_WALK,
        ST_TAIL,
        ST_ALLOC,
        ST_POP,
        ST_WR_NEW,
        ST_WR_PREV,
        ST_WR_FREED,
        ST_DONE
    } state_t;

endpackage

@@ design/ffna_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module ffna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

@@ design/first_fit_named_allocator.sv @@
// Top level of the named first-fit allocator: controller, name table and block list.
`timescale 1ns / 1ps

// Each transaction on s_ is one command (allocate, free or print) and produces exactly one
// transaction on m_ carrying an address and a status. Commands are handled one at a time:
// the name table memory is scanned one entry per cycle up to the number of names seen so
// far, then an allocate or free walks the address-ordered block list one block per cycle
// through the block memory read port, followed by the block and name table writes. A
// command of the unused kind skips the search and goes straight to its result. A new
// result waits while the previous result still holds the output register. The result
// sits in an output register, so the next command is taken while the previous result
// waits. Both memories start undefined and need no clearing pass; a name fill count,
// a high-water mark and a free list of block entries track what is in use.

module first_fit_named_allocator #(
    parameter int MAX_BLOCKS = ffna_pkg::MAX_BLOCKS_DEF,
    parameter int MAX_NAMES  = ffna_pkg::MAX_NAMES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ffna_pkg::S_TDATA_W-1:0] s_tdata,  // name_key[31:0], alloc_size[48:32]
    input  logic [ffna_pkg::KIND_W-1:0]    s_tuser,  // kind[1:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ffna_pkg::M_TDATA_W-1:0] m_tdata,  // address[16:0]
    output logic [ffna_pkg::STAT_W-1:0]    m_tuser   // status[1:0]
);

    import ffna_pkg::*;

    localparam int NIW = $clog2(MAX_NAMES);
    localparam int NCW = $clog2(MAX_NAMES + 1);
    localparam int BIW = $clog2(MAX_BLOCKS);
    localparam int BCW = $clog2(MAX_BLOCKS + 1);
    localparam int BLW = BIW + 1;
    localparam int TW  = KEY_W + 1 + BIW;
    localparam int BW  = 2 * ADDR_W + BLW;

    localparam logic [BLW-1:0]    LIST_END  = BLW'(MAX_BLOCKS);
    localparam logic [ADDR_W-1:0] GAP_FIRST = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] TOP_END   = ADDR_W'(ADDR_LIMIT + 1);

    // Registers
    state_t              state_reg, state_next;
    kind_t               kind_reg, kind_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [NCW-1:0]      name_cnt_reg, name_cnt_next;
    logic [NCW-1:0]      ni_reg, ni_next;
    logic [NIW-1:0]      chk_reg, chk_next;
    logic                rvld_reg, rvld_next;
    logic                found_reg, found_next;
    logic [NIW-1:0]      tidx_reg, tidx_next;
    logic                tbound_reg, tbound_next;
    logic [BIW-1:0]      tblk_reg, tblk_next;
    logic [BLW-1:0]      list_first_reg, list_first_next;
    logic [BLW-1:0]      free_head_reg, free_head_next;
    logic [BCW-1:0]      hw_cnt_reg, hw_cnt_next;
    logic [BLW-1:0]      cur_reg, cur_next;
    logic [BLW-1:0]      prev_reg, prev_next;
    logic [ADDR_W-1:0]   prev_start_reg, prev_start_next;
    logic [ADDR_W-1:0]   prev_end_reg, prev_end_next;
    logic [ADDR_W-1:0]   gap_lo_reg, gap_lo_next;
    logic [BIW-1:0]      bsel_reg, bsel_next;
    logic [BLW-1:0]      blink_reg, blink_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    status_t             res_stat_reg, res_stat_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [ADDR_W-1:0]   m_addr_reg, m_addr_next;
    status_t             m_stat_reg, m_stat_next;

    // Memory ports
    logic            t_we;
    logic [NIW-1:0]  t_waddr, t_raddr;
    logic [TW-1:0]   t_wdata, t_rdata;
    logic            b_we;
    logic [BIW-1:0]  b_waddr, b_raddr;
    logic [BW-1:0]   b_wdata, b_rdata;

    // Name table: key, bound flag, block index
    ffna_ram #(.WIDTH(TW), .DEPTH(MAX_NAMES)) u_tag_ram (
        .aclk    (aclk),
        .wr_en   (t_we),
        .wr_addr (t_waddr),
        .wr_data (t_wdata),
        .rd_addr (t_raddr),
        .rd_data (t_rdata)
    );

    // Block table: start, end, link (also chains the free list)
    ffna_ram #(.WIDTH(BW), .DEPTH(MAX_BLOCKS)) u_blk_ram (
        .aclk    (aclk),
        .wr_en   (b_we),
        .wr_addr (b_waddr),
        .wr_data (b_wdata),
        .rd_addr (b_raddr),
        .rd_data (b_rdata)
    );

    // Read data fields
    logic [KEY_W-1:0]  rt_key;
    logic              rt_bound;
    logic [BIW-1:0]    rt_blk;
    logic [ADDR_W-1:0] rb_start, rb_end;
    logic [BLW-1:0]    rb_link;

    assign rt_key   = t_rdata[TW-1 -: KEY_W];
    assign rt_bound = t_rdata[BIW];
    assign rt_blk   = t_rdata[BIW-1:0];
    assign rb_start = b_rdata[BW-1 -: ADDR_W];
    assign rb_end   = b_rdata[BLW+ADDR_W-1 -: ADDR_W];
    assign rb_link  = b_rdata[BLW-1:0];

    // Shared conditions
    logic  s_take, is_alloc, name_hit, name_more, names_full;
    logic  walk_fit, tail_fit, walk_hit, link_end, free_avail, hw_avail, out_free;
    kind_t s_kind;

    assign s_take     = s_tvalid && s_tready;
    assign s_kind     = kind_t'(s_tuser);
    assign is_alloc   = (kind_reg == KIND_ALLOC);
    assign name_hit   = rvld_reg && (rt_key == key_reg);
    assign name_more  = (ni_reg < name_cnt_reg);
    assign names_full = (name_cnt_reg == NCW'(MAX_NAMES));
    assign walk_fit   = ((rb_start - gap_lo_reg) >= size_reg);
    assign tail_fit   = ((TOP_END - gap_lo_reg) >= size_reg);
    assign walk_hit   = (cur_reg == BLW'(bsel_reg));
    assign link_end   = (rb_link == LIST_END);
    assign free_avail = (free_head_reg != LIST_END);
    assign hw_avail   = (hw_cnt_reg != BCW'(MAX_BLOCKS));
    assign out_free   = !m_tvalid_reg || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_take) begin
                    state_next = (s_kind == KIND_NONE) ? ST_DONE : ST_NSCAN;
                end
            end
            ST_NSCAN: begin
                if (name_hit || !name_more) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (is_alloc) begin
                    if (!found_reg && names_full) begin
                        state_next = ST_DONE;
                    end else if (list_first_reg == LIST_END) begin
                        state_next = ST_TAIL;
                    end else begin
                        state_next = ST_WALK;
                    end
                end else if (found_reg && tbound_reg) begin
                    state_next = ST_BLOCK;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_BLOCK: begin
                state_next = (kind_reg == KIND_PRINT) ? ST_DONE : ST_WALK;
            end
            ST_WALK: begin
                if (is_alloc) begin
                    if (walk_fit) begin
                        state_next = ST_ALLOC;
                    end else if (link_end) begin
                        state_next = ST_TAIL;
                    end
                end else if (walk_hit) begin
                    state_next = ST_WR_PREV;
                end else if (link_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_TAIL: begin
                state_next = tail_fit ? ST_ALLOC : ST_DONE;
            end
            ST_ALLOC: begin
                if (free_avail) begin
                    state_next = ST_POP;
                end else if (hw_avail) begin
                    state_next = ST_WR_NEW;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_POP:      state_next = ST_WR_NEW;
            ST_WR_NEW:   state_next = ST_WR_PREV;
            ST_WR_PREV:  state_next = is_alloc ? ST_DONE : ST_WR_FREED;
            ST_WR_FREED: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath, memory controls and result
    always_comb begin
        kind_next       = kind_reg;
        key_next        = key_reg;
        size_next       = size_reg;
        name_cnt_next   = name_cnt_reg;
        ni_next         = ni_reg;
        chk_next        = chk_reg;
        rvld_next       = rvld_reg;
        found_next      = found_reg;
        tidx_next       = tidx_reg;
        tbound_next     = tbound_reg;
        tblk_next       = tblk_reg;
        list_first_next = list_first_reg;
        free_head_next  = free_head_reg;
        hw_cnt_next     = hw_cnt_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        prev_start_next = prev_start_reg;
        prev_end_next   = prev_end_reg;
        gap_lo_next     = gap_lo_reg;
        bsel_next       = bsel_reg;
        blink_next      = blink_reg;
        res_addr_next   = res_addr_reg;
        res_stat_next   = res_stat_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_addr_next     = m_addr_reg;
        m_stat_next     = m_stat_reg;

        t_we    = 1'b0;
        t_waddr = tidx_reg;
        t_wdata = {key_reg, 1'b0, tblk_reg};
        t_raddr = ni_reg[NIW-1:0];
        b_we    = 1'b0;
        b_waddr = bsel_reg;
        b_wdata = {prev_start_reg, prev_end_reg, blink_reg};
        b_raddr = bsel_reg;

        // Result register drains on its handshake
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_take) begin
                    kind_next     = s_kind;
                    key_next      = s_tdata[KEY_W-1:0];
                    size_next     = s_tdata[KEY_W+SIZE_W-1:KEY_W];
                    ni_next       = '0;
                    rvld_next     = 1'b0;
                    found_next    = 1'b0;
                    res_addr_next = '0;
                    res_stat_next = STAT_UNKNOWN;
                end
            end
            // Pipelined name search: issue entry ni, compare entry chk
            ST_NSCAN: begin
                if (name_hit) begin
                    found_next  = 1'b1;
                    tidx_next   = chk_reg;
                    tbound_next = rt_bound;
                    tblk_next   = rt_blk;
                    rvld_next   = 1'b0;
                end else if (name_more) begin
                    t_raddr   = ni_reg[NIW-1:0];
                    chk_next  = ni_reg[NIW-1:0];
                    rvld_next = 1'b1;
                    ni_next   = ni_reg + NCW'(1);
                end else begin
                    rvld_next = 1'b0;
                end
            end
            ST_DISPATCH: begin
                if (is_alloc) begin
                    gap_lo_next = GAP_FIRST;
                    prev_next   = LIST_END;
                    cur_next    = list_first_reg;
                    b_raddr     = list_first_reg[BIW-1:0];
                    if (!found_reg) begin
                        if (names_full) begin
                            res_stat_next = STAT_FULL;
                        end else begin
                            tidx_next     = name_cnt_reg[NIW-1:0];
                            name_cnt_next = name_cnt_reg + NCW'(1);
                        end
                    end
                end else begin
                    bsel_next = tblk_reg;
                    b_raddr   = tblk_reg;
                end
            end
            // Bound block read back: report its start, start the unlink walk for free
            ST_BLOCK: begin
                res_addr_next = rb_start;
                res_stat_next = STAT_OK;
                prev_next     = LIST_END;
                cur_next      = list_first_reg;
                b_raddr       = list_first_reg[BIW-1:0];
                if (kind_reg == KIND_FREE) begin
                    t_we = 1'b1;
                end
            end
            // One list entry per cycle; next address comes straight from the link
            ST_WALK: begin
                if (is_alloc && walk_fit) begin
                    cur_next = cur_reg;
                end else if (!is_alloc && walk_hit) begin
                    blink_next = rb_link;
                end else begin
                    gap_lo_next     = rb_end;
                    prev_next       = cur_reg;
                    prev_start_next = rb_start;
                    prev_end_next   = rb_end;
                    cur_next        = rb_link;
                    b_raddr         = rb_link[BIW-1:0];
                end
            end
            ST_TAIL: begin
                if (!tail_fit) begin
                    res_stat_next = STAT_NOFIT;
                    t_we          = 1'b1;
                end
            end
            // Pick a block entry: free list first, then the high-water mark
            ST_ALLOC: begin
                if (free_avail) begin
                    bsel_next = free_head_reg[BIW-1:0];
                    b_raddr   = free_head_reg[BIW-1:0];
                end else if (hw_avail) begin
                    bsel_next   = hw_cnt_reg[BIW-1:0];
                    hw_cnt_next = hw_cnt_reg + BCW'(1);
                end else begin
                    res_stat_next = STAT_FULL;
                    t_we          = 1'b1;
                end
            end
            ST_POP: begin
                free_head_next = rb_link;
            end
            ST_WR_NEW: begin
                b_we          = 1'b1;
                b_waddr       = bsel_reg;
                b_wdata       = {gap_lo_reg, gap_lo_reg + ADDR_W'(size_reg), cur_reg};
                t_we          = 1'b1;
                t_wdata       = {key_reg, 1'b1, bsel_reg};
                res_addr_next = gap_lo_reg;
                res_stat_next = STAT_OK;
                blink_next    = BLW'(bsel_reg);
            end
            // Relink the predecessor (or the list head)
            ST_WR_PREV: begin
                if (prev_reg == LIST_END) begin
                    list_first_next = blink_reg;
                end else begin
                    b_we    = 1'b1;
                    b_waddr = prev_reg[BIW-1:0];
                    b_wdata = {prev_start_reg, prev_end_reg, blink_reg};
                end
            end
            // Push the released entry on the free list
            ST_WR_FREED: begin
                b_we           = 1'b1;
                b_waddr        = bsel_reg;
                b_wdata        = {{ADDR_W{1'b0}}, {ADDR_W{1'b0}}, free_head_reg};
                free_head_next = BLW'(bsel_reg);
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_addr_next   = res_addr_reg;
                    m_stat_next   = res_stat_reg;
                end
            end
            default: begin
                rvld_next = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            name_cnt_reg   <= '0;
            list_first_reg <= LIST_END;
            free_head_reg  <= LIST_END;
            hw_cnt_reg     <= '0;
            rvld_reg       <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            name_cnt_reg   <= name_cnt_next;
            list_first_reg <= list_first_next;
            free_head_reg  <= free_head_next;
            hw_cnt_reg     <= hw_cnt_next;
            rvld_reg       <= rvld_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        size_reg       <= size_next;
        ni_reg         <= ni_next;
        chk_reg        <= chk_next;
        found_reg      <= found_next;
        tidx_reg       <= tidx_next;
        tbound_reg     <= tbound_next;
        tblk_reg       <= tblk_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        prev_start_reg <= prev_start_next;
        prev_end_reg   <= prev_end_next;
        gap_lo_reg     <= gap_lo_next;
        bsel_reg       <= bsel_next;
        blink_reg      <= blink_next;
        res_addr_reg   <= res_addr_next;
        res_stat_reg   <= res_stat_next;
        m_addr_reg     <= m_addr_next;
        m_stat_reg     <= m_stat_next;
    end

    // Ports
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - ADDR_W){1'b0}}, m_addr_reg};
    assign m_tuser  = m_stat_reg;

endmodule

@@ design/ffna_checker.sv @@
// Port-level checks for the named first-fit allocator, bound to the top level.
`timescale 1ns / 1ps

module ffna_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [ffna_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [ffna_pkg::KIND_W-1:0]    s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ffna_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [ffna_pkg::STAT_W-1:0]    m_tuser
);

    import ffna_pkg::*;

    // No result survives reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // One command at a time: an accepted command closes the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted in back-to-back cycles");

    // Failures report a null address
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != STAT_OK) |-> (m_tdata == '0))
        else $error("failed command with nonzero address");

    // Success always reports a real address
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STAT_OK) |-> (m_tdata != '0))
        else $error("successful command with null address");

endmodule

bind first_fit_named_allocator ffna_checker u_ffna_checker (.*);

@@ sim/tb.sv @@
// Self-checking testbench for the named first-fit allocator.
`timescale 1ns / 1ps

module tb;
    import ffna_pkg::*;

    localparam int NBLK = MAX_BLOCKS_DEF;
    localparam int NTAG = MAX_NAMES_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        status_t           st;
    } alloc_result_t;

    typedef struct {
        kind_t             kind;
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] size;
        bit                typed;
        logic [ADDR_W-1:0] addr;
        status_t           st;
    } cmd_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // name_key[31:0], alloc_size[48:32]
    logic [KIND_W-1:0]    s_tuser;   // kind[1:0]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;   // address[16:0]
    logic [STAT_W-1:0]    m_tuser;   // status[1:0]

    first_fit_named_allocator DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // Shadow copy of the allocator state
    int unsigned mdl_start [NBLK];
    int unsigned mdl_end   [NBLK];
    int unsigned mdl_link  [NBLK];
    bit          mdl_bused [NBLK];
    int unsigned mdl_head;
    int unsigned mdl_key   [NTAG];
    int unsigned mdl_tblk  [NTAG];
    bit          mdl_bound [NTAG];
    bit          mdl_tused [NTAG];

    alloc_result_t pending_results[$];
    int            errors;
    bit            idle_en;
    int            stall_cnt = 0;
    int            quiet_cycles = 0;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // Compute one command's outcome and update the shadow state
    task automatic predict_command(input kind_t kind, input int unsigned key,
                                   input int unsigned size, output alloc_result_t res);
        int unsigned t, b, prev, cur, gap_lo, steps;
        bit fits;
        res.addr = '0;
        res.st   = STAT_UNKNOWN;
        t = NTAG;
        for (int i = 0; i < NTAG; i++)
            if (t == NTAG && mdl_tused[i] && mdl_key[i] == key) t = i;
        if (kind == KIND_ALLOC) begin
            if (t == NTAG) begin
                for (int i = 0; i < NTAG; i++)
                    if (t == NTAG && !mdl_tused[i]) t = i;
                if (t < NTAG) begin
                    mdl_tused[t] = 1'b1;
                    mdl_key[t]   = key;
                    mdl_bound[t] = 1'b0;
                    mdl_tblk[t]  = 0;
                end
            end
            if (t == NTAG) begin
                res.st = STAT_FULL;
            end else begin
                prev = NBLK; cur = mdl_head; gap_lo = 1; steps = 0; fits = 1'b0;
                while (!fits && cur < NBLK && steps < NBLK) begin
                    if (mdl_start[cur] - gap_lo >= size) begin
                        fits = 1'b1;
                    end else begin
                        gap_lo = mdl_end[cur];
                        prev = cur;
                        cur = mdl_link[cur];
                        steps++;
                    end
                end
                if (!fits && ADDR_LIMIT + 1 - gap_lo >= size) fits = 1'b1;
                mdl_bound[t] = 1'b0;
                if (!fits) begin
                    res.st = STAT_NOFIT;
                end else begin
                    b = NBLK;
                    for (int i = 0; i < NBLK; i++)
                        if (b == NBLK && !mdl_bused[i]) b = i;
                    if (b == NBLK) begin
                        res.st = STAT_FULL;
                    end else begin
                        mdl_bused[b] = 1'b1;
                        mdl_start[b] = gap_lo;
                        mdl_end[b]   = gap_lo + size;
                        mdl_link[b]  = cur;
                        if (prev < NBLK) mdl_link[prev] = b;
                        else mdl_head = b;
                        mdl_bound[t] = 1'b1;
                        mdl_tblk[t]  = b;
                        res.addr = gap_lo[ADDR_W-1:0];
                        res.st   = STAT_OK;
                    end
                end
            end
        end else if (kind == KIND_FREE || kind == KIND_PRINT) begin
            if (t < NTAG && mdl_bound[t] && mdl_tblk[t] < NBLK) begin
                b = mdl_tblk[t];
                res.addr = mdl_start[b][ADDR_W-1:0];
                res.st   = STAT_OK;
                if (kind == KIND_FREE) begin
                    // unlink from the address-ordered list
                    prev = NBLK; cur = mdl_head; steps = 0;
                    while (cur < NBLK && steps < NBLK) begin
                        if (cur == b) begin
                            if (prev < NBLK) mdl_link[prev] = mdl_link[cur];
                            else mdl_head = mdl_link[cur];
                            steps = NBLK;
                        end else begin
                            prev = cur;
                            cur = mdl_link[cur];
                            steps++;
                        end
                    end
                    mdl_bused[b] = 1'b0;
                    mdl_bound[t] = 1'b0;
                end
            end
        end
    endtask

    // Drive one command, wait until it is accepted and queue its expected result
    task automatic send_command(input cmd_row_t row);
        alloc_result_t res;
        int gap;
        gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= row.kind;
        s_tdata  <= {7'd0, row.size, row.key};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_command(row.kind, row.key, row.size, res);
        if (row.typed) begin
            res.addr = row.addr;
            res.st   = row.st;
        end
        pending_results.push_back(res);
    endtask

    // Result side: check and random stall bursts
    always @(posedge aclk) begin
        alloc_result_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no command outstanding");
            end else begin
                exp_res = pending_results.pop_front();
                if (m_tdata[ADDR_W-1:0] !== exp_res.addr)
                    report_mismatch($sformatf("address %0d, expected %0d",
                                              m_tdata[ADDR_W-1:0], exp_res.addr));
                if (m_tuser !== exp_res.st)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_tuser, exp_res.st));
            end
        end
        if (stall_cnt > 0) begin
            stall_cnt <= stall_cnt - 1;
            m_tready  <= 1'b0;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            stall_cnt <= $urandom_range(0, 12);
            m_tready  <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog on stalled traffic
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Stimulus
    initial begin
        cmd_row_t dir_rows[$];
        cmd_row_t row;
        int unsigned pick;
        errors = 0; idle_en = 1'b1;
        aresetn = 1'b0; s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
        mdl_head = NBLK;
        for (int i = 0; i < NBLK; i++) mdl_bused[i] = 1'b0;
        for (int i = 0; i < NTAG; i++) begin
            mdl_tused[i] = 1'b0;
            mdl_bound[i] = 1'b0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed commands: empty table, extremes, null and unknown names
        dir_rows = '{
            '{KIND_PRINT, 32'h41414141, 17'd0,      1, 17'd0, STAT_UNKNOWN},
            '{KIND_FREE,  32'h41414141, 17'd0,      1, 17'd0, STAT_UNKNOWN},
            '{KIND_NONE,  32'h41414141, 17'd5,      1, 17'd0, STAT_UNKNOWN},
            '{KIND_ALLOC, 32'h41414141, 17'd0,      1, 17'd1, STAT_OK},
            '{KIND_ALLOC, 32'h42424242, 17'd65536,  1, 17'd1, STAT_OK},
            '{KIND_ALLOC, 32'h43434343, 17'd1,      1, 17'd0, STAT_NOFIT},
            '{KIND_PRINT, 32'h43434343, 17'd0,      1, 17'd0, STAT_UNKNOWN},
            '{KIND_FREE,  32'h43434343, 17'd0,      1, 17'd0, STAT_UNKNOWN},
            '{KIND_PRINT, 32'h42424242, 17'd0,      1, 17'd1, STAT_OK},
            '{KIND_FREE,  32'h42424242, 17'd0,      1, 17'd1, STAT_OK},
            '{KIND_FREE,  32'h42424242, 17'd0,      1, 17'd0, STAT_UNKNOWN},
            '{KIND_ALLOC, 32'h00000000, 17'h1FFFF,  1, 17'd0, STAT_NOFIT},
            '{KIND_ALLOC, 32'hFFFFFFFF, 17'd100,    0, 17'd0, STAT_OK},
            '{KIND_ALLOC, 32'h42424242, 17'd7,      0, 17'd0, STAT_OK},
            '{KIND_ALLOC, 32'h41414141, 17'd3,      0, 17'd0, STAT_OK},
            '{KIND_PRINT, 32'h41414141, 17'd0,      0, 17'd0, STAT_OK},
            '{KIND_FREE,  32'hFFFFFFFF, 17'd0,      0, 17'd0, STAT_OK},
            '{KIND_ALLOC, 32'h44444444, 17'd50,     0, 17'd0, STAT_OK},
            '{KIND_ALLOC, 32'h45454545, 17'd0,      0, 17'd0, STAT_OK},
            '{KIND_ALLOC, 32'h46464646, 17'd65000,  0, 17'd0, STAT_OK},
            '{KIND_PRINT, 32'h46464646, 17'd0,      0, 17'd0, STAT_OK}
        };
        foreach (dir_rows[i]) send_command(dir_rows[i]);

        // Random mix over a small name pool with some wild names
        for (int n = 0; n < 130; n++) begin
            pick = $urandom_range(0, 99);
            row.kind = pick < 50 ? KIND_ALLOC : pick < 75 ? KIND_FREE :
                       pick < 95 ? KIND_PRINT : KIND_NONE;
            row.key = ($urandom_range(0, 99) < 85) ?
                      (32'h4E300000 | $urandom_range(0, 19)) : $urandom;
            pick = $urandom_range(0, 99);
            row.size = SIZE_W'(pick < 70 ? $urandom_range(0, 300) :
                               pick < 90 ? $urandom_range(0, 8000) :
                                           $urandom_range(0, 17'h1FFFF));
            row.typed = 1'b0;
            send_command(row);
        end

        // Hold off until every outstanding result is back
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);

        // Fill both tables, then hit the full cases; no idling from here on
        idle_en = 1'b0;
        row.typed = 1'b0;
        for (int n = 0; n < 280; n++) begin
            row.kind = KIND_ALLOC;
            row.key  = 32'hF0000000 | n;
            row.size = 17'd1;
            send_command(row);
        end
        for (int n = 0; n < 20; n++) begin
            pick = $urandom_range(0, 2);
            row.kind = pick == 0 ? KIND_ALLOC : pick == 1 ? KIND_FREE : KIND_PRINT;
            row.key  = (n % 2) ? (32'hF0000000 | $urandom_range(0, 320)) :
                                 (32'h4E300000 | $urandom_range(0, 19));
            row.size = SIZE_W'($urandom_range(0, 40));
            send_command(row);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
